@@ rtl/bps_pkg.sv @@
// types, codes and constants of the bps patch applier
// depends on nothing; imported by bps_patch_apply

package bps_pkg;

   // command codes of an input transaction
   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_SOURCE = 2'd1;
   localparam logic [1:0] CMD_PATCH  = 2'd2;
   localparam logic [1:0] CMD_READ   = 2'd3;

   // status codes of a result
   localparam logic [2:0] STAT_RUNNING   = 3'd0;
   localparam logic [2:0] STAT_DONE      = 3'd1;
   localparam logic [2:0] STAT_BAD_MAGIC = 3'd2;
   localparam logic [2:0] STAT_SIZE      = 3'd3;
   localparam logic [2:0] STAT_RANGE     = 3'd4;
   localparam logic [2:0] STAT_SRC_CRC   = 3'd5;
   localparam logic [2:0] STAT_TGT_CRC   = 3'd6;
   localparam logic [2:0] STAT_PATCH_CRC = 3'd7;

   // segment kinds
   localparam logic [1:0] SEG_SOURCE_READ = 2'd0;
   localparam logic [1:0] SEG_TARGET_READ = 2'd1;
   localparam logic [1:0] SEG_SOURCE_COPY = 2'd2;
   localparam logic [1:0] SEG_TARGET_COPY = 2'd3;

   localparam logic [31:0] CRC_INIT  = 32'hffffffff;
   localparam logic [31:0] CRC_POLY  = 32'hedb88320;
   localparam logic [6:0]  NUM_MASK  = 7'h7f;
   localparam logic [39:0] NUM_SAT   = 40'hffffffff;
   localparam int          TAIL_LEN  = 12;
   localparam logic [3:0]  TAIL_FULL = 4'd12;

   // "BPS1"
   localparam logic [7:0] MAGIC_0 = 8'h42;
   localparam logic [7:0] MAGIC_1 = 8'h50;
   localparam logic [7:0] MAGIC_2 = 8'h53;
   localparam logic [7:0] MAGIC_3 = 8'h31;

   typedef enum logic [3:0] {
      PH_MAGIC, PH_SRCSZ, PH_TGTSZ, PH_METALEN, PH_METASKIP,
      PH_HEAD, PH_TREAD, PH_OFFSET, PH_DONE, PH_FAILED
   } phase_type;

   typedef enum logic [2:0] {
      CS_IDLE, CS_DECODE, CS_COPY_RD, CS_COPY_WR, CS_FINISH, CS_FIN_CRC, CS_READ, CS_RESP
   } ctl_state_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  data;
      logic [15:0] addr;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  read_data;
      logic [16:0] target_length;
      logic [31:0] stored_patch_crc;
   } rsp_type;

   typedef struct packed {
      logic [31:0] accum;
      logic [5:0]  shift;
      logic        done;
   } num_type;

endpackage

@@ rtl/bps_patch_apply.sv @@
// bps delta patch applier: source and target memories, header and segment decode
// depends on bps_pkg
//
//   channel   ports                          handshake
//   request   start, busy, req_item          taken when start and not busy
//   response  rsp_valid, rsp_item            one cycle strobe, cannot be held off
//
// every transaction gives one response; start, source load and an out-of-range read
// answer in the cycle after acceptance, an in-range read after CS_READ (target port).
// a patch byte may pass CS_DECODE, then CS_COPY_RD and CS_COPY_WR for each copied byte
// (read then write of the memories); the final byte adds CS_FINISH and CS_FIN_CRC for
// the trailer crc, one byte per cycle. a new transaction is taken in the response cycle.
// reset is synchronous; the memories are not cleared and read back only what was written.

module bps_patch_apply #(
   parameter int SOURCE_DEPTH = 65536,
   parameter int TARGET_DEPTH = 65536
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  bps_pkg::req_type req_item,
   output logic             busy,
   output logic             rsp_valid,
   output bps_pkg::rsp_type rsp_item
);
   import bps_pkg::*;

   localparam int SAW = $clog2(SOURCE_DEPTH);
   localparam int TAW = $clog2(TARGET_DEPTH);
   localparam int SCW = $clog2(SOURCE_DEPTH + 1);
   localparam int TCW = $clog2(TARGET_DEPTH + 1);
   localparam logic [32:0] SDEPTH = 33'(SOURCE_DEPTH);
   localparam logic [32:0] TDEPTH = 33'(TARGET_DEPTH);

   // memories
   logic [7:0] src_mem [SOURCE_DEPTH];
   logic [7:0] tgt_mem [TARGET_DEPTH];
   logic [7:0] src_q_ff, tgt_q_ff;
   logic           sw_en, tw_en;
   logic [SAW-1:0] sw_addr, sr_addr;
   logic [TAW-1:0] tw_addr, tr_addr;
   logic [7:0]     tw_data;

   // control and decode state
   ctl_state_type  state_ff, state_in;
   phase_type      phase_ff, phase_in;
   logic [7:0]     tail_ff [TAIL_LEN];
   logic [7:0]     tail_in [TAIL_LEN];
   logic [3:0]     fill_ff, fill_in;
   logic [31:0]    accum_ff, accum_in;
   logic [5:0]     shift_ff, shift_in;
   logic [SCW-1:0] src_cnt_ff, src_cnt_in;
   logic [TCW-1:0] tgt_cnt_ff, tgt_cnt_in;
   logic [31:0]    tsize_ff, tsize_in;
   logic [31:0]    srel_ff, srel_in;
   logic [31:0]    trel_ff, trel_in;
   logic [1:0]     kind_ff, kind_in;
   logic [31:0]    seg_rem_ff, seg_rem_in;
   logic [31:0]    meta_rem_ff, meta_rem_in;
   logic [31:0]    crc_src_ff, crc_src_in;
   logic [31:0]    crc_tgt_ff, crc_tgt_in;
   logic [31:0]    crc_pat_ff, crc_pat_in;
   logic [2:0]     err_ff, err_in;
   logic [7:0]     byte_ff, byte_in;
   logic           last_ff, last_in;
   logic [7:0]     rd_ff, rd_in;
   logic [3:0]     fin_idx_ff, fin_idx_in;

   // helpers
   num_type        nf;
   logic [31:0]    src_cnt32, tgt_cnt32, addr32, nv;
   logic [32:0]    seg_len, end_pos;
   logic [31:0]    new_srel, new_trel, fin_crc;
   logic [31:0]    tw0, tw1, tw2;
   logic [7:0]     magic_byte, copy_byte;

   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   // one byte of a variable-length number, saturating at all ones
   function automatic num_type num_feed(input logic [31:0] acc, input logic [5:0] sh_in,
                                        input logic [7:0] b);
      logic [39:0] a;
      logic [5:0]  sh;
      num_type     r;
      a  = {8'd0, acc};
      sh = sh_in;
      if (b[6:0] != 7'd0) begin
         if (sh >= 6'd32) a = NUM_SAT;
         else a = a + ({33'd0, b[6:0] & NUM_MASK} << sh[4:0]);
      end
      if (a > NUM_SAT) a = NUM_SAT;
      if (b[7]) begin
         r.accum = a[31:0];
         r.shift = 6'd0;
         r.done  = 1'b1;
      end else begin
         sh = sh + 6'd7;
         if (sh >= 6'd32) a = NUM_SAT;
         else a = a + (40'd1 << sh[4:0]);
         if (a > NUM_SAT) a = NUM_SAT;
         if (sh > 6'd35) sh = 6'd35;
         r.accum = a[31:0];
         r.shift = sh;
         r.done  = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [31:0] apply_offset(input logic [31:0] rel, input logic [31:0] v);
      return v[0] ? (rel - {1'b0, v[31:1]}) : (rel + {1'b0, v[31:1]});
   endfunction

   // shared decode terms
   assign src_cnt32 = 32'(src_cnt_ff);
   assign tgt_cnt32 = 32'(tgt_cnt_ff);
   assign addr32    = 32'(req_item.addr);
   assign nf        = num_feed(accum_ff, shift_ff, byte_ff);
   assign nv        = nf.accum;
   assign seg_len   = 33'(nv[31:2]) + 33'd1;
   assign end_pos   = 33'(tgt_cnt32) + seg_len;
   assign new_srel  = apply_offset(srel_ff, nv);
   assign new_trel  = apply_offset(trel_ff, nv);
   assign fin_crc   = crc_byte(crc_pat_ff, tail_ff[fin_idx_ff]);
   assign tw0 = {tail_ff[3], tail_ff[2], tail_ff[1], tail_ff[0]};
   assign tw1 = {tail_ff[7], tail_ff[6], tail_ff[5], tail_ff[4]};
   assign tw2 = {tail_ff[11], tail_ff[10], tail_ff[9], tail_ff[8]};
   assign copy_byte = (kind_ff == SEG_TARGET_COPY) ? tgt_q_ff : src_q_ff;

   always_comb begin
      case (shift_ff[1:0])
         2'd0:    magic_byte = MAGIC_0;
         2'd1:    magic_byte = MAGIC_1;
         2'd2:    magic_byte = MAGIC_2;
         default: magic_byte = MAGIC_3;
      endcase
   end

   // source memory: load port and copy read port
   always_ff @(posedge clock) begin
      if (sw_en) src_mem[sw_addr] <= req_item.data;
      src_q_ff <= src_mem[sr_addr];
   end

   // target memory: decode write port and read port
   always_ff @(posedge clock) begin
      if (tw_en) tgt_mem[tw_addr] <= tw_data;
      tgt_q_ff <= tgt_mem[tr_addr];
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= CS_IDLE;
         phase_ff    <= PH_MAGIC;
         for (int i = 0; i < TAIL_LEN; i++) tail_ff[i] <= 8'd0;
         fill_ff     <= 4'd0;
         accum_ff    <= 32'd0;
         shift_ff    <= 6'd0;
         src_cnt_ff  <= '0;
         tgt_cnt_ff  <= '0;
         tsize_ff    <= 32'd0;
         srel_ff     <= 32'd0;
         trel_ff     <= 32'd0;
         kind_ff     <= SEG_SOURCE_READ;
         seg_rem_ff  <= 32'd0;
         meta_rem_ff <= 32'd0;
         crc_src_ff  <= CRC_INIT;
         crc_tgt_ff  <= CRC_INIT;
         crc_pat_ff  <= CRC_INIT;
         err_ff      <= STAT_RUNNING;
         last_ff     <= 1'b0;
         rd_ff       <= 8'd0;
         fin_idx_ff  <= 4'd0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         for (int i = 0; i < TAIL_LEN; i++) tail_ff[i] <= tail_in[i];
         fill_ff     <= fill_in;
         accum_ff    <= accum_in;
         shift_ff    <= shift_in;
         src_cnt_ff  <= src_cnt_in;
         tgt_cnt_ff  <= tgt_cnt_in;
         tsize_ff    <= tsize_in;
         srel_ff     <= srel_in;
         trel_ff     <= trel_in;
         kind_ff     <= kind_in;
         seg_rem_ff  <= seg_rem_in;
         meta_rem_ff <= meta_rem_in;
         crc_src_ff  <= crc_src_in;
         crc_tgt_ff  <= crc_tgt_in;
         crc_pat_ff  <= crc_pat_in;
         err_ff      <= err_in;
         last_ff     <= last_in;
         rd_ff       <= rd_in;
         fin_idx_ff  <= fin_idx_in;
      end
      byte_ff <= byte_in;
   end

   // next state and memory control
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      for (int i = 0; i < TAIL_LEN; i++) tail_in[i] = tail_ff[i];
      fill_in     = fill_ff;
      accum_in    = accum_ff;
      shift_in    = shift_ff;
      src_cnt_in  = src_cnt_ff;
      tgt_cnt_in  = tgt_cnt_ff;
      tsize_in    = tsize_ff;
      srel_in     = srel_ff;
      trel_in     = trel_ff;
      kind_in     = kind_ff;
      seg_rem_in  = seg_rem_ff;
      meta_rem_in = meta_rem_ff;
      crc_src_in  = crc_src_ff;
      crc_tgt_in  = crc_tgt_ff;
      crc_pat_in  = crc_pat_ff;
      err_in      = err_ff;
      byte_in     = byte_ff;
      last_in     = last_ff;
      rd_in       = rd_ff;
      fin_idx_in  = fin_idx_ff;
      sw_en   = 1'b0;
      sw_addr = src_cnt32[SAW-1:0];
      sr_addr = tgt_cnt32[SAW-1:0];
      tw_en   = 1'b0;
      tw_addr = tgt_cnt32[TAW-1:0];
      tw_data = byte_ff;
      tr_addr = addr32[TAW-1:0];

      case (state_ff)
         CS_IDLE, CS_RESP: begin
            state_in = CS_IDLE;
            if (start) begin
               last_in  = req_item.last;
               rd_in    = 8'd0;
               state_in = CS_RESP;
               case (req_item.cmd)
                  CMD_START: begin
                     phase_in    = PH_MAGIC;
                     for (int i = 0; i < TAIL_LEN; i++) tail_in[i] = 8'd0;
                     fill_in     = 4'd0;
                     accum_in    = 32'd0;
                     shift_in    = 6'd0;
                     src_cnt_in  = '0;
                     tgt_cnt_in  = '0;
                     tsize_in    = 32'd0;
                     srel_in     = 32'd0;
                     trel_in     = 32'd0;
                     kind_in     = SEG_SOURCE_READ;
                     seg_rem_in  = 32'd0;
                     meta_rem_in = 32'd0;
                     crc_src_in  = CRC_INIT;
                     crc_tgt_in  = CRC_INIT;
                     crc_pat_in  = CRC_INIT;
                     err_in      = STAT_RUNNING;
                  end
                  CMD_SOURCE: begin
                     if (phase_ff == PH_MAGIC && fill_ff == 4'd0 &&
                         33'(src_cnt32) < SDEPTH) begin
                        sw_en      = 1'b1;
                        crc_src_in = crc_byte(crc_src_ff, req_item.data);
                        src_cnt_in = src_cnt_ff + SCW'(1);
                     end
                  end
                  CMD_PATCH: begin
                     if (phase_ff != PH_DONE && phase_ff != PH_FAILED) begin
                        for (int i = 0; i < TAIL_LEN - 1; i++) tail_in[i] = tail_ff[i+1];
                        tail_in[TAIL_LEN-1] = req_item.data;
                        byte_in = tail_ff[0];
                        if (fill_ff >= TAIL_FULL) begin
                           state_in = CS_DECODE;
                        end else begin
                           fill_in = fill_ff + 4'd1;
                           if (req_item.last) state_in = CS_FINISH;
                        end
                     end
                  end
                  default: begin
                     if (addr32 < tgt_cnt32 && 33'(addr32) < TDEPTH) state_in = CS_READ;
                  end
               endcase
            end
         end

         CS_READ: begin
            rd_in    = tgt_q_ff;
            state_in = CS_RESP;
         end

         // one delayed patch byte through the header and segment decoder
         CS_DECODE: begin
            crc_pat_in = crc_byte(crc_pat_ff, byte_ff);
            state_in   = last_ff ? CS_FINISH : CS_RESP;
            case (phase_ff)
               PH_MAGIC: begin
                  if (byte_ff != magic_byte) begin
                     err_in = STAT_BAD_MAGIC; phase_in = PH_FAILED;
                  end else if (shift_ff == 6'd3) begin
                     shift_in = 6'd0; phase_in = PH_SRCSZ;
                  end else begin
                     shift_in = shift_ff + 6'd1;
                  end
               end
               PH_SRCSZ, PH_TGTSZ, PH_METALEN: begin
                  accum_in = nf.done ? 32'd0 : nf.accum;
                  shift_in = nf.shift;
                  if (nf.done) begin
                     if (phase_ff == PH_SRCSZ) begin
                        if (nv != src_cnt32) begin
                           err_in = STAT_SIZE; phase_in = PH_FAILED;
                        end else phase_in = PH_TGTSZ;
                     end else if (phase_ff == PH_TGTSZ) begin
                        tsize_in = nv;
                        if (33'(nv) > TDEPTH) begin
                           err_in = STAT_RANGE; phase_in = PH_FAILED;
                        end else phase_in = PH_METALEN;
                     end else begin
                        meta_rem_in = nv;
                        phase_in    = (nv != 32'd0) ? PH_METASKIP : PH_HEAD;
                     end
                  end
               end
               PH_METASKIP: begin
                  meta_rem_in = meta_rem_ff - 32'd1;
                  if (meta_rem_ff == 32'd1) phase_in = PH_HEAD;
               end
               PH_HEAD: begin
                  accum_in = nf.done ? 32'd0 : nf.accum;
                  shift_in = nf.shift;
                  if (nf.done) begin
                     kind_in = nv[1:0];
                     if (end_pos > 33'(tsize_ff)) begin
                        err_in = STAT_RANGE; phase_in = PH_FAILED;
                     end else begin
                        seg_rem_in = seg_len[31:0];
                        case (nv[1:0])
                           SEG_SOURCE_READ: begin
                              if (end_pos > 33'(src_cnt32)) begin
                                 err_in = STAT_RANGE; phase_in = PH_FAILED;
                              end else state_in = CS_COPY_RD;
                           end
                           SEG_TARGET_READ: phase_in = PH_TREAD;
                           default:         phase_in = PH_OFFSET;
                        endcase
                     end
                  end
               end
               PH_TREAD: begin
                  tw_en      = 1'b1;
                  crc_tgt_in = crc_byte(crc_tgt_ff, byte_ff);
                  tgt_cnt_in = tgt_cnt_ff + TCW'(1);
                  seg_rem_in = seg_rem_ff - 32'd1;
                  if (seg_rem_ff == 32'd1) phase_in = PH_HEAD;
               end
               PH_OFFSET: begin
                  accum_in = nf.done ? 32'd0 : nf.accum;
                  shift_in = nf.shift;
                  if (nf.done) begin
                     if (kind_ff == SEG_SOURCE_COPY) begin
                        srel_in = new_srel;
                        if (new_srel[31] ||
                            33'(new_srel) + 33'(seg_rem_ff) > 33'(src_cnt32)) begin
                           err_in = STAT_RANGE; phase_in = PH_FAILED;
                        end else state_in = CS_COPY_RD;
                     end else begin
                        trel_in = new_trel;
                        if (new_trel[31] || new_trel >= tgt_cnt32) begin
                           err_in = STAT_RANGE; phase_in = PH_FAILED;
                        end else state_in = CS_COPY_RD;
                     end
                  end
               end
               default: begin
               end
            endcase
         end

         // copy loop: read one byte, then write it at the target end
         CS_COPY_RD: begin
            if (kind_ff == SEG_SOURCE_COPY) sr_addr = srel_ff[SAW-1:0];
            tr_addr  = trel_ff[TAW-1:0];
            state_in = CS_COPY_WR;
         end

         CS_COPY_WR: begin
            tw_en      = 1'b1;
            tw_data    = copy_byte;
            crc_tgt_in = crc_byte(crc_tgt_ff, copy_byte);
            tgt_cnt_in = tgt_cnt_ff + TCW'(1);
            seg_rem_in = seg_rem_ff - 32'd1;
            if (kind_ff == SEG_SOURCE_COPY) srel_in = srel_ff + 32'd1;
            if (kind_ff == SEG_TARGET_COPY) trel_in = trel_ff + 32'd1;
            if (seg_rem_ff == 32'd1) begin
               phase_in = PH_HEAD;
               state_in = last_ff ? CS_FINISH : CS_RESP;
            end else begin
               state_in = CS_COPY_RD;
            end
         end

         // trailer checks on the final patch byte
         CS_FINISH: begin
            state_in = CS_RESP;
            if (phase_ff == PH_FAILED || phase_ff == PH_DONE) begin
            end else if (phase_ff == PH_MAGIC) begin
               err_in = STAT_BAD_MAGIC; phase_in = PH_FAILED;
            end else if (fill_ff < TAIL_FULL || phase_ff != PH_HEAD || shift_ff != 6'd0 ||
                         tgt_cnt32 != tsize_ff) begin
               err_in = STAT_SIZE; phase_in = PH_FAILED;
            end else if (tw0 != ~crc_src_ff) begin
               err_in = STAT_SRC_CRC; phase_in = PH_FAILED;
            end else if (tw1 != ~crc_tgt_ff) begin
               err_in = STAT_TGT_CRC; phase_in = PH_FAILED;
            end else begin
               fin_idx_in = 4'd0;
               state_in   = CS_FIN_CRC;
            end
         end

         // fold the two stored checksums into the patch crc, one byte a cycle
         CS_FIN_CRC: begin
            crc_pat_in = fin_crc;
            fin_idx_in = fin_idx_ff + 4'd1;
            if (fin_idx_ff == 4'd7) begin
               state_in = CS_RESP;
               if (tw2 != ~fin_crc) begin
                  err_in = STAT_PATCH_CRC; phase_in = PH_FAILED;
               end else phase_in = PH_DONE;
            end
         end

         default: state_in = CS_IDLE;
      endcase
   end

   // response
   assign busy      = (state_ff != CS_IDLE) && (state_ff != CS_RESP);
   assign rsp_valid = (state_ff == CS_RESP);
   assign rsp_item.status = (err_ff != STAT_RUNNING) ? err_ff :
                            ((phase_ff == PH_DONE) ? STAT_DONE : STAT_RUNNING);
   assign rsp_item.read_data        = rd_ff;
   assign rsp_item.target_length    = tsize_ff[16:0];
   assign rsp_item.stored_patch_crc = tw2;

endmodule

@@ tb/sv/tb_bps_patch_apply.sv @@
// self-checking testbench of the bps patch applier: directed jobs, then random patch jobs
// depends on bps_pkg and bps_patch_apply; predicts every response with its own model

module tb_bps_patch_apply;
   import bps_pkg::*;

   localparam int MEM_DEPTH  = 65536;
   localparam int WDOG_LIMIT = 5000;
   localparam int ITEM_GOAL  = 1800;

   // ways a generated patch job can be damaged
   localparam int F_NONE      = 0;
   localparam int F_FLIP      = 1;
   localparam int F_CUT       = 2;
   localparam int F_SRC_CRC   = 3;
   localparam int F_TGT_CRC   = 4;
   localparam int F_PATCH_CRC = 5;
   localparam int F_LATE      = 6;

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_item;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   bps_patch_apply u_dut (
      .clock(clock), .reset(reset), .start(start), .req_item(req_item),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // predictor state
   logic [7:0]  src_mem [0:MEM_DEPTH-1];
   logic [7:0]  tgt_mem [0:MEM_DEPTH-1];
   logic [7:0]  tail_q [0:11];
   int unsigned tail_cnt;
   phase_type   ph;
   logic [31:0] acc;
   int unsigned nshift;
   int unsigned src_cnt;
   int unsigned tgt_cnt;
   logic [31:0] tgt_size, src_rel, tgt_rel, seg_left, meta_left;
   logic [1:0]  seg_kind;
   logic [31:0] crc_s, crc_t, crc_p;
   logic [2:0]  err_code;

   rsp_type     expected_rsp[$];
   int          n_errors;
   int          n_sent;
   bit          idle_on;
   int          wdog;

   // patch generator buffers
   logic [7:0]  pbuf[$];
   logic [7:0]  bbody[$];
   logic [7:0]  gsrc[$];
   logic [7:0]  gtgt[$];

   function automatic logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
      c = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   function automatic logic [7:0] magic_at(int i);
      case (i & 3)
         0: return MAGIC_0;
         1: return MAGIC_1;
         2: return MAGIC_2;
         default: return MAGIC_3;
      endcase
   endfunction

   function automatic void job_clear();
      for (int i = 0; i < TAIL_LEN; i++) tail_q[i] = 8'd0;
      tail_cnt = 0; ph = PH_MAGIC; acc = 0; nshift = 0; src_cnt = 0; tgt_cnt = 0;
      tgt_size = 0; src_rel = 0; tgt_rel = 0; seg_kind = 0; seg_left = 0; meta_left = 0;
      crc_s = CRC_INIT; crc_t = CRC_INIT; crc_p = CRC_INIT; err_code = STAT_RUNNING;
   endfunction

   function automatic void set_fail(logic [2:0] code);
      err_code = code;
      ph = PH_FAILED;
   endfunction

   function automatic void tgt_write(logic [7:0] b);
      if (tgt_cnt < MEM_DEPTH) tgt_mem[tgt_cnt] = b;
      crc_t = crc_next(crc_t, b);
      tgt_cnt++;
   endfunction

   // variable-length number, saturating; returns 1 when complete
   function automatic bit num_feed(logic [7:0] b);
      longint unsigned a;
      int unsigned sh;
      longint unsigned part;
      a = acc; sh = nshift; part = b & 8'h7f;
      if (part != 0) begin
         if (sh >= 32) a = 64'hffffffff; else a = a + (part << sh);
      end
      if (a > 64'hffffffff) a = 64'hffffffff;
      if (b[7]) begin
         acc = a[31:0]; nshift = 0;
         return 1'b1;
      end
      sh = sh + 7;
      if (sh >= 32) a = 64'hffffffff; else a = a + (64'd1 << sh);
      if (a > 64'hffffffff) a = 64'hffffffff;
      if (sh > 35) sh = 35;
      acc = a[31:0]; nshift = sh;
      return 1'b0;
   endfunction

   function automatic logic [31:0] num_take();
      logic [31:0] v;
      v = acc; acc = 0;
      return v;
   endfunction

   function automatic logic [31:0] rel_move(logic [31:0] rel, logic [31:0] v);
      return v[0] ? rel - (v >> 1) : rel + (v >> 1);
   endfunction

   // copy segment once its offset is known
   function automatic void copy_run(logic [31:0] v);
      longint len;
      longint pos;
      longint unsigned a;
      len = seg_left;
      if (seg_kind == SEG_SOURCE_COPY) begin
         src_rel = rel_move(src_rel, v);
         pos = longint'($signed(src_rel));
         if (pos < 0 || pos + len > src_cnt) begin
            set_fail(STAT_RANGE);
            return;
         end
         for (longint i = 0; i < len; i++) tgt_write(src_mem[pos + i]);
         src_rel = src_rel + len[31:0];
      end else begin
         tgt_rel = rel_move(tgt_rel, v);
         pos = longint'($signed(tgt_rel));
         if (pos < 0 || pos >= tgt_cnt) begin
            set_fail(STAT_RANGE);
            return;
         end
         for (longint i = 0; i < len; i++) begin
            a = pos + i;
            tgt_write(a < MEM_DEPTH ? tgt_mem[a] : 8'd0);
         end
         tgt_rel = tgt_rel + len[31:0];
      end
      seg_left = 0;
      ph = PH_HEAD;
   endfunction

   // one byte leaving the delay line
   function automatic void decode(logic [7:0] b);
      logic [31:0] v;
      longint len;
      crc_p = crc_next(crc_p, b);
      case (ph)
         PH_MAGIC: begin
            if (b != magic_at(nshift)) set_fail(STAT_BAD_MAGIC);
            else begin
               nshift++;
               if (nshift >= 4) begin
                  nshift = 0; ph = PH_SRCSZ;
               end
            end
         end
         PH_SRCSZ: if (num_feed(b)) begin
            if (num_take() != src_cnt) set_fail(STAT_SIZE); else ph = PH_TGTSZ;
         end
         PH_TGTSZ: if (num_feed(b)) begin
            tgt_size = num_take();
            if (tgt_size > MEM_DEPTH) set_fail(STAT_RANGE); else ph = PH_METALEN;
         end
         PH_METALEN: if (num_feed(b)) begin
            meta_left = num_take();
            ph = (meta_left != 0) ? PH_METASKIP : PH_HEAD;
         end
         PH_METASKIP: begin
            meta_left--;
            if (meta_left == 0) ph = PH_HEAD;
         end
         PH_HEAD: if (num_feed(b)) begin
            v = num_take();
            seg_kind = v[1:0];
            len = longint'(v >> 2) + 1;
            if (tgt_cnt + len > tgt_size) set_fail(STAT_RANGE);
            else begin
               seg_left = len[31:0];
               if (seg_kind == SEG_SOURCE_READ) begin
                  if (tgt_cnt + len > src_cnt) set_fail(STAT_RANGE);
                  else begin
                     for (longint i = 0; i < len; i++) tgt_write(src_mem[tgt_cnt]);
                     seg_left = 0;
                  end
               end else if (seg_kind == SEG_TARGET_READ) ph = PH_TREAD;
               else ph = PH_OFFSET;
            end
         end
         PH_TREAD: begin
            tgt_write(b);
            seg_left--;
            if (seg_left == 0) ph = PH_HEAD;
         end
         PH_OFFSET: if (num_feed(b)) copy_run(num_take());
         default: ;
      endcase
   endfunction

   function automatic logic [31:0] tail_word(int at);
      return {tail_q[at+3], tail_q[at+2], tail_q[at+1], tail_q[at]};
   endfunction

   // trailer check on the final patch byte
   function automatic void trailer_check();
      logic [31:0] c;
      if (ph == PH_FAILED || ph == PH_DONE) return;
      if (ph == PH_MAGIC) begin
         set_fail(STAT_BAD_MAGIC);
         return;
      end
      if (tail_cnt < 12 || ph != PH_HEAD || nshift != 0 || tgt_cnt != tgt_size) begin
         set_fail(STAT_SIZE);
         return;
      end
      if (tail_word(0) != ~crc_s) begin
         set_fail(STAT_SRC_CRC);
         return;
      end
      if (tail_word(4) != ~crc_t) begin
         set_fail(STAT_TGT_CRC);
         return;
      end
      c = crc_p;
      for (int i = 0; i < 8; i++) c = crc_next(c, tail_q[i]);
      crc_p = c;
      if (tail_word(8) != ~c) begin
         set_fail(STAT_PATCH_CRC);
         return;
      end
      ph = PH_DONE;
   endfunction

   function automatic rsp_type predict_rsp(req_type r);
      rsp_type o;
      logic [7:0] popped;
      logic [7:0] rd;
      rd = 8'd0;
      case (r.cmd)
         CMD_START: job_clear();
         CMD_SOURCE: if (ph == PH_MAGIC && tail_cnt == 0 && src_cnt < MEM_DEPTH) begin
            src_mem[src_cnt] = r.data;
            crc_s = crc_next(crc_s, r.data);
            src_cnt++;
         end
         CMD_PATCH: if (ph != PH_DONE && ph != PH_FAILED) begin
            popped = tail_q[0];
            for (int i = 0; i < 11; i++) tail_q[i] = tail_q[i+1];
            tail_q[11] = r.data;
            if (tail_cnt >= 12) decode(popped); else tail_cnt++;
            if (r.last) trailer_check();
         end
         default: if (r.addr < tgt_cnt) rd = tgt_mem[r.addr];
      endcase
      o.status = (err_code != 0) ? err_code : (ph == PH_DONE ? STAT_DONE : STAT_RUNNING);
      o.read_data = rd;
      o.target_length = tgt_size[16:0];
      o.stored_patch_crc = tail_word(8);
      return o;
   endfunction

   // response checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            n_errors++;
            if (n_errors <= 10) $display("unexpected response %h", rsp_item);
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_item.status !== e.status || rsp_item.read_data !== e.read_data ||
                rsp_item.target_length !== e.target_length ||
                rsp_item.stored_patch_crc !== e.stored_patch_crc) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("mismatch: status %0d/%0d rd %h/%h len %0d/%0d crc %h/%h",
                           e.status, rsp_item.status, e.read_data, rsp_item.read_data,
                           e.target_length, rsp_item.target_length,
                           e.stored_patch_crc, rsp_item.stored_patch_crc);
            end
         end
      end
   end

   // watchdog on cycles with no transaction moving
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) wdog <= 0;
      else wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // one request transaction; called and returns at a falling edge
   task automatic send_item(logic [1:0] cmd, logic [7:0] data, logic [15:0] addr,
                            logic last);
      req_type r;
      if (idle_on && $urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 10)) @(negedge clock);
      r.cmd = cmd; r.data = data; r.addr = addr; r.last = last;
      req_item = r;
      start = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_rsp.push_back(predict_rsp(r));
      n_sent++;
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic send_noise_fields(logic [1:0] cmd);
      send_item(cmd, 8'($urandom), 16'($urandom), 1'($urandom));
   endtask

   task automatic wait_drain();
      while (expected_rsp.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_patch();
      for (int i = 0; i < pbuf.size(); i++)
         send_item(CMD_PATCH, pbuf[i], 16'($urandom), i == pbuf.size() - 1);
   endtask

   task automatic push_num(longint unsigned d);
      logic [7:0] x;
      forever begin
         x = 8'(d & 64'h7f);
         d = d >> 7;
         if (d == 0) begin
            pbuf.push_back(x | 8'h80);
            break;
         end
         pbuf.push_back(x);
         d = d - 1;
      end
   endtask

   task automatic push_le(logic [31:0] w);
      for (int i = 0; i < 4; i++) pbuf.push_back(w[8*i +: 8]);
   endtask

   task automatic push_magic();
      for (int i = 0; i < 4; i++) pbuf.push_back(magic_at(i));
   endtask

   // segment header or offset number into the body buffer
   task automatic body_num(longint unsigned d);
      int n;
      n = pbuf.size();
      push_num(d);
      for (int i = n; i < pbuf.size(); i++) bbody.push_back(pbuf[i]);
      while (pbuf.size() > n) void'(pbuf.pop_back());
   endtask

   function automatic longint unsigned offs_code(longint d);
      return d < 0 ? (((-d) << 1) | 1) : (d << 1);
   endfunction

   // header with a chosen target size (or an oversized one), body from bbody, then a zero trailer
   task automatic raw_job(int ns, longint tsize, bit oversize);
      send_noise_fields(CMD_START);
      for (int i = 0; i < ns; i++) send_noise_fields(CMD_SOURCE);
      pbuf.delete();
      push_magic();
      push_num(ns);
      if (oversize) begin
         repeat (6) pbuf.push_back(8'h7f);
         pbuf.push_back(8'h81);
      end else push_num(tsize);
      push_num(0);
      foreach (bbody[i]) pbuf.push_back(bbody[i]);
      repeat (12) pbuf.push_back(8'h00);
      send_patch();
      bbody.delete();
   endtask

   // generated job: source load, well-formed patch (maybe damaged), read back
   task automatic run_job(int nload, int nseg, int fault, bit extra);
      int nsrc, len, kind, pos, meta, n;
      int srel, trel;
      logic [31:0] c;
      send_noise_fields(CMD_START);
      gsrc.delete(); gtgt.delete(); bbody.delete(); pbuf.delete();
      for (int i = 0; i < nload; i++) begin
         logic [7:0] b;
         b = 8'($urandom);
         if (gsrc.size() < MEM_DEPTH) gsrc.push_back(b);
         send_item(CMD_SOURCE, b, 16'($urandom), 1'($urandom));
      end
      nsrc = gsrc.size();
      srel = 0; trel = 0;
      for (int k = 0; k < nseg; k++) begin
         kind = $urandom_range(0, 3);
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         if (kind == SEG_SOURCE_READ && gtgt.size() + len > nsrc) kind = SEG_TARGET_READ;
         if (kind == SEG_SOURCE_COPY && nsrc == 0) kind = SEG_TARGET_READ;
         if (kind == SEG_TARGET_COPY && gtgt.size() == 0) kind = SEG_TARGET_READ;
         if (kind == SEG_SOURCE_COPY && len > nsrc) len = nsrc;
         body_num(((len - 1) << 2) | kind);
         case (kind)
            SEG_SOURCE_READ: for (int i = 0; i < len; i++) gtgt.push_back(gsrc[gtgt.size()]);
            SEG_TARGET_READ: for (int i = 0; i < len; i++) begin
               bbody.push_back(8'($urandom));
               gtgt.push_back(bbody[$]);
            end
            SEG_SOURCE_COPY: begin
               pos = $urandom_range(0, nsrc - len);
               body_num(offs_code(pos - srel));
               for (int i = 0; i < len; i++) gtgt.push_back(gsrc[pos + i]);
               srel = pos + len;
            end
            default: begin
               pos = $urandom_range(0, gtgt.size() - 1);
               body_num(offs_code(pos - trel));
               for (int i = 0; i < len; i++) gtgt.push_back(gtgt[pos + i]);
               trel = pos + len;
            end
         endcase
      end
      push_magic();
      push_num(nsrc);
      push_num(gtgt.size());
      meta = $urandom_range(0, 3);
      push_num(meta);
      repeat (meta) pbuf.push_back(8'($urandom));
      foreach (bbody[i]) pbuf.push_back(bbody[i]);
      c = CRC_INIT;
      foreach (gsrc[i]) c = crc_next(c, gsrc[i]);
      push_le(~c);
      c = CRC_INIT;
      foreach (gtgt[i]) c = crc_next(c, gtgt[i]);
      push_le(~c);
      c = CRC_INIT;
      foreach (pbuf[i]) c = crc_next(c, pbuf[i]);
      push_le(~c);
      n = pbuf.size();
      case (fault)
         F_FLIP: pbuf[$urandom_range(0, n - 1)] ^= 8'($urandom_range(1, 255));
         F_CUT: pbuf = pbuf[0:$urandom_range(0, n - 2)];
         F_SRC_CRC: pbuf[n-12] ^= 8'($urandom_range(1, 255));
         F_TGT_CRC: pbuf[n-8] ^= 8'($urandom_range(1, 255));
         F_PATCH_CRC: pbuf[n-4] ^= 8'($urandom_range(1, 255));
         default: ;
      endcase
      for (int i = 0; i < pbuf.size(); i++) begin
         send_item(CMD_PATCH, pbuf[i], 16'($urandom), i == pbuf.size() - 1);
         // a source byte after the patch has begun is dropped
         if (fault == F_LATE && i == 0) send_noise_fields(CMD_SOURCE);
      end
      if (extra) repeat (2) send_noise_fields(CMD_PATCH);
      repeat ($urandom_range(2, 6)) begin
         if (gtgt.size() > 0 && $urandom_range(0, 2) != 0)
            send_item(CMD_READ, 8'($urandom), 16'($urandom_range(0, gtgt.size() - 1)),
                      1'($urandom));
         else send_noise_fields(CMD_READ);
      end
   endtask

   task automatic test_magic_and_truncation();
      send_noise_fields(CMD_START);
      pbuf.delete();
      pbuf.push_back(MAGIC_0); pbuf.push_back(MAGIC_1); pbuf.push_back(8'h58);
      repeat (14) pbuf.push_back(8'hff);
      send_patch();
      send_item(CMD_PATCH, 8'h00, 16'hffff, 1'b1);
      send_noise_fields(CMD_START);
      pbuf.delete();
      push_magic();
      send_patch();
      run_job(5, 3, F_CUT, 1'b0);
   endtask

   task automatic test_header_numbers();
      raw_job(0, 0, 1'b1);
      raw_job(0, MEM_DEPTH + 1, 1'b0);
      run_job(0, 2, F_NONE, 1'b1);
   endtask

   task automatic test_segment_range();
      body_num(((3 - 1) << 2) | SEG_TARGET_READ);
      raw_job(0, 2, 1'b0);
      body_num(((2 - 1) << 2) | SEG_SOURCE_READ);
      raw_job(1, 4, 1'b0);
      body_num(SEG_SOURCE_COPY);
      body_num(offs_code(-1));
      raw_job(4, 4, 1'b0);
      body_num(SEG_TARGET_COPY);
      body_num(offs_code(0));
      raw_job(0, 4, 1'b0);
   endtask

   task automatic test_crc_and_done();
      run_job(6, 4, F_SRC_CRC, 1'b0);
      run_job(6, 4, F_TGT_CRC, 1'b0);
      run_job(6, 4, F_PATCH_CRC, 1'b0);
      run_job(6, 5, F_LATE, 1'b1);
      wait_drain();
   endtask

   task automatic test_random_jobs();
      int goal, fault, jobs;
      goal = ITEM_GOAL;
      jobs = 0;
      while (n_sent < goal) begin
         if (goal - n_sent < 300) idle_on = 1'b0;
         fault = ($urandom_range(0, 9) < 6) ? F_NONE : $urandom_range(F_FLIP, F_LATE);
         if ($urandom_range(0, 7) == 0) send_noise_fields(2'($urandom));
         run_job($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 24),
                 $urandom_range(1, 8), fault, $urandom_range(0, 9) == 0);
         jobs++;
         if (jobs % 5 == 0) wait_drain();
      end
   endtask

   initial begin
      start = 1'b0;
      req_item = '0;
      reset = 1'b1;
      n_errors = 0;
      n_sent = 0;
      idle_on = 1'b1;
      wdog = 0;
      job_clear();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_magic_and_truncation();
      test_header_numbers();
      test_segment_range();
      test_crc_and_done();
      test_random_jobs();
      wait_drain();
      repeat (30) @(posedge clock);
      if (n_errors == 0 && expected_rsp.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
